// File: design/cgd_pkg.sv
// Package for the conjugate gradient direction block.
// Holds payload structs, controller/datapath command types and constants.
package cgd_pkg;

  localparam int GridElements = 4096;
  localparam int IndexWidth = 12;

  localparam logic [1:0] ModeCompute = 2'd0;
  localparam logic [1:0] ModeInit = 2'd1;
  localparam logic [1:0] ModeZero = 2'd2;

  localparam logic OpAccumulate = 1'b0;
  localparam logic OpApply = 1'b1;

  localparam logic KindDirection = 1'b0;
  localparam logic KindBeta = 1'b1;

  localparam logic [16:0] BetaMax = 17'd32768;

  typedef struct packed {
    logic operation;
    logic [11:0] element_index;
    logic last;
    logic signed [31:0] grad_a;
    logic signed [31:0] grad_b;
    logic signed [31:0] grad_c;
  } in_word_t;

  typedef struct packed {
    logic kind;
    logic [11:0] out_index;
    logic signed [31:0] dir_a;
    logic signed [31:0] dir_b;
    logic signed [31:0] dir_c;
    logic [15:0] beta_a;
    logic [15:0] beta_b;
    logic [15:0] beta_c;
  } out_word_t;

  typedef struct packed {
    logic capture;
    logic read;
    logic mult;
    logic accum;
    logic div_start;
    logic div_step;
    logic div_done;
    logic emit_dir;
    logic init_only;
  } cmd_t;

  typedef struct packed {
    logic is_apply;
    logic is_last;
    logic is_init;
    logic div_end;
  } status_t;

endpackage

// File: design/cgd_datapath.sv
// Datapath: gradient and direction memories, products, accumulators,
// restoring divider and result register. Uses cgd_pkg.
module cgd_datapath (
  input  logic clk,
  input  logic rst,
  input  logic [1:0] mode,
  input  cgd_pkg::in_word_t in_word,
  input  cgd_pkg::cmd_t cmd,
  output cgd_pkg::status_t status,
  output logic result_valid,
  output cgd_pkg::out_word_t result
);

  logic signed [31:0] grad_mem [3][cgd_pkg::GridElements];
  logic signed [31:0] dir_mem [3][cgd_pkg::GridElements];

  cgd_pkg::in_word_t item;
  logic signed [31:0] gp [3];
  logic signed [31:0] pd [3];
  logic signed [63:0] nprod [3];
  logic signed [63:0] dprod [3];
  logic signed [63:0] bprod [3];
  logic signed [63:0] num_sum [3];
  logic signed [63:0] den_sum [3];
  logic [16:0] beta_store [3];
  logic [63:0] rem [3];
  logic [16:0] quo [3];
  logic [2:0] trivial;
  logic [4:0] step;
  logic signed [31:0] g [3];
  logic signed [63:0] dsum [3];
  logic signed [31:0] dir_new [3];

  assign g[0] = item.grad_a;
  assign g[1] = item.grad_b;
  assign g[2] = item.grad_c;
  assign status.is_apply = item.operation == cgd_pkg::OpApply;
  assign status.is_last = item.last;
  assign status.is_init = mode == cgd_pkg::ModeInit;
  assign status.div_end = step == 5'd15;

  function automatic logic signed [63:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s;
  endfunction

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dsum[c] = (bprod[c] >>> 16) + 64'(g[c]);
      if (dsum[c] > 64'sd2147483647) begin
        dir_new[c] = 32'sh7FFF_FFFF;
      end else if (dsum[c] < -64'sd2147483648) begin
        dir_new[c] = 32'sh8000_0000;
      end else begin
        dir_new[c] = dsum[c][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= in_word;
    end
    for (int c = 0; c < 3; c++) begin
      if (cmd.read) begin
        gp[c] <= grad_mem[c][item.element_index];
        pd[c] <= dir_mem[c][item.element_index];
      end
      if (cmd.read && !status.is_apply) begin
        grad_mem[c][item.element_index] <= g[c];
        if (cmd.init_only) begin
          dir_mem[c][item.element_index] <= g[c];
        end
      end else if (cmd.emit_dir) begin
        dir_mem[c][item.element_index] <= dir_new[c];
      end
      if (cmd.mult) begin
        nprod[c] <= 64'(g[c]) * (64'(g[c]) - 64'(gp[c]));
        dprod[c] <= 64'(gp[c]) * 64'(gp[c]);
        bprod[c] <= 64'(pd[c]) * $signed({47'd0, beta_store[c]});
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [64:0] r2;
    cgd_pkg::out_word_t word;
    word = '0;
    if (rst) begin
      for (int c = 0; c < 3; c++) begin
        num_sum[c] <= '0;
        den_sum[c] <= '0;
        beta_store[c] <= '0;
      end
      step <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.accum) begin
        for (int c = 0; c < 3; c++) begin
          num_sum[c] <= sat_add(num_sum[c], nprod[c]);
          den_sum[c] <= sat_add(den_sum[c], dprod[c]);
        end
      end
      if (cmd.emit_dir) begin
        word.kind = cgd_pkg::KindDirection;
        word.out_index = item.element_index;
        word.dir_a = dir_new[0];
        word.dir_b = dir_new[1];
        word.dir_c = dir_new[2];
        result <= word;
      end
      if (cmd.div_start) begin
        step <= '0;
        for (int c = 0; c < 3; c++) begin
          rem[c] <= num_sum[c];
          if (mode == cgd_pkg::ModeInit || mode == cgd_pkg::ModeZero ||
              den_sum[c] <= 0 || num_sum[c] <= 0) begin
            trivial[c] <= 1'b1;
            quo[c] <= '0;
          end else if (num_sum[c] >= den_sum[c]) begin
            trivial[c] <= 1'b1;
            quo[c] <= cgd_pkg::BetaMax;
          end else begin
            trivial[c] <= 1'b0;
            quo[c] <= '0;
          end
        end
      end
      if (cmd.div_step) begin
        step <= step + 5'd1;
        for (int c = 0; c < 3; c++) begin
          if (!trivial[c]) begin
            r2 = {rem[c], 1'b0};
            if (r2 >= {1'b0, den_sum[c]}) begin
              rem[c] <= 64'(r2 - {1'b0, den_sum[c]});
              quo[c] <= {quo[c][15:0], 1'b1};
            end else begin
              rem[c] <= r2[63:0];
              quo[c] <= {quo[c][15:0], 1'b0};
            end
          end
        end
      end
      if (cmd.div_done) begin
        for (int c = 0; c < 3; c++) begin
          beta_store[c] <= quo[c] > cgd_pkg::BetaMax ? cgd_pkg::BetaMax : quo[c];
          num_sum[c] <= '0;
          den_sum[c] <= '0;
        end
        word.kind = cgd_pkg::KindBeta;
        word.beta_a = quo[0] > cgd_pkg::BetaMax ? 16'(cgd_pkg::BetaMax) : quo[0][15:0];
        word.beta_b = quo[1] > cgd_pkg::BetaMax ? 16'(cgd_pkg::BetaMax) : quo[1][15:0];
        word.beta_c = quo[2] > cgd_pkg::BetaMax ? 16'(cgd_pkg::BetaMax) : quo[2][15:0];
        result <= word;
      end
      result_valid <= cmd.emit_dir || (cmd.div_done && !status.is_init);
    end
  end

endmodule

// File: design/cgd_control.sv
// Controller state machine sequencing the datapath.
// Uses cgd_pkg command and status types.
module cgd_control (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  cgd_pkg::status_t status,
  output cgd_pkg::cmd_t cmd,
  output logic busy
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StMult = 3'd2;
  localparam logic [2:0] StAcc = 3'd3;
  localparam logic [2:0] StDivInit = 3'd4;
  localparam logic [2:0] StDiv = 3'd5;
  localparam logic [2:0] StDone = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign busy = state != StIdle;

  always_comb begin
    cmd = '0;
    state_next = state;
    cmd.capture = state == StIdle && start;
    unique case (state)
      StIdle: if (start) state_next = StRead;
      StRead: begin
        cmd.read = 1'b1;
        cmd.init_only = status.is_init;
        state_next = StMult;
      end
      StMult: begin
        cmd.mult = 1'b1;
        state_next = StAcc;
      end
      StAcc: begin
        if (status.is_apply) begin
          cmd.emit_dir = 1'b1;
          state_next = StIdle;
        end else begin
          cmd.accum = !status.is_init;
          state_next = status.is_last ? StDivInit : StIdle;
        end
      end
      StDivInit: begin
        cmd.div_start = 1'b1;
        state_next = StDiv;
      end
      StDiv: begin
        cmd.div_step = 1'b1;
        if (status.div_end) state_next = StDone;
      end
      StDone: begin
        cmd.div_done = 1'b1;
        state_next = StIdle;
      end
      default: state_next = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: design/conjugate_gradient_direction.sv
// Top level of the conjugate gradient direction block.
// Instantiates cgd_control and cgd_datapath; uses cgd_pkg.
//
// Usage: a word is taken on start while busy is low. Accumulate words fold
// each gradient against the stored previous gradient into saturating
// sums (in init mode they seed the stored directions instead); apply words
// emit a direction word built from the stored betas. An apply word's
// direction appears on result with done high after the read, multiply and
// accumulate states. The last accumulate word then runs three sixteen-step
// restoring dividers side by side, one per component, before the beta
// word (not emitted in init mode); a new word waits until busy is low.
// Each result stands for exactly one cycle; the receiver cannot stall.
// The user writes the mode register with cfg_we and cfg_data while idle;
// the block itself does not enforce this.
// Reset clears sums, betas and control, and sets mode to one.
module conjugate_gradient_direction (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  cgd_pkg::in_word_t in_word,
  output logic busy,
  output logic done,
  output cgd_pkg::out_word_t result,
  input  logic cfg_we,
  input  logic [1:0] cfg_data
);

  logic [1:0] mode;
  cgd_pkg::cmd_t cmd;
  cgd_pkg::status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= cgd_pkg::ModeInit;
    end else if (cfg_we) begin
      mode <= cfg_data;
    end
  end

  cgd_control u_control (
    .clk(clk), .rst(rst), .start(start), .status(status), .cmd(cmd), .busy(busy)
  );

  cgd_datapath u_datapath (
    .clk(clk), .rst(rst), .mode(mode), .in_word(in_word), .cmd(cmd),
    .status(status), .result_valid(done), .result(result)
  );

endmodule

// File: verif/tb.sv
// Self-checking testbench for the conjugate gradient direction block.
// Depends on cgd_pkg and conjugate_gradient_direction; holds its own predictor.
`timescale 1ns / 1ps

module tb;

  localparam int Limit = 600000;

  class direction_scoreboard;
    int prev_grad[3][cgd_pkg::GridElements];
    int prev_dir[3][cgd_pkg::GridElements];
    longint num_sum[3];
    longint den_sum[3];
    int unsigned betas[3];
    logic [1:0] mode;
    cgd_pkg::out_word_t expected_words[$];
    int mismatches;

    function new();
      mode = cgd_pkg::ModeInit;
      mismatches = 0;
      foreach (num_sum[c]) begin
        num_sum[c] = 0;
        den_sum[c] = 0;
        betas[c] = 0;
      end
    endfunction

    function longint sat_add(longint a, longint b);
      longint s;
      s = a + b;
      if (a > 0 && b > 0 && s < 0) return 64'sh7FFF_FFFF_FFFF_FFFF;
      if (a < 0 && b < 0 && s >= 0) return 64'sh8000_0000_0000_0000;
      return s;
    endfunction

    function int unsigned quotient(longint n, longint d);
      longint unsigned r, q;
      if (d <= 0 || n <= 0) return 0;
      if (n >= d) return cgd_pkg::BetaMax;
      r = n;
      q = 0;
      for (int i = 0; i < 16; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= d) begin
          r = r - d;
          q = q | 1;
        end
      end
      return (q > cgd_pkg::BetaMax) ? cgd_pkg::BetaMax : int'(q);
    endfunction

    function void note_input(cgd_pkg::in_word_t w);
      longint g[3];
      longint gp, d;
      int idx;
      cgd_pkg::out_word_t e;
      idx = w.element_index;
      g[0] = w.grad_a;
      g[1] = w.grad_b;
      g[2] = w.grad_c;
      e = '0;
      if (w.operation == cgd_pkg::OpAccumulate) begin
        for (int c = 0; c < 3; c++) begin
          if (mode == cgd_pkg::ModeInit) begin
            prev_dir[c][idx] = int'(g[c]);
          end else begin
            gp = prev_grad[c][idx];
            num_sum[c] = sat_add(num_sum[c], g[c] * (g[c] - gp));
            den_sum[c] = sat_add(den_sum[c], gp * gp);
          end
          prev_grad[c][idx] = int'(g[c]);
        end
        if (!w.last) return;
        for (int c = 0; c < 3; c++) begin
          betas[c] = (mode == cgd_pkg::ModeInit || mode == cgd_pkg::ModeZero) ? 0
                     : quotient(num_sum[c], den_sum[c]);
          num_sum[c] = 0;
          den_sum[c] = 0;
        end
        if (mode == cgd_pkg::ModeInit) return;
        e.kind = cgd_pkg::KindBeta;
        e.beta_a = betas[0][15:0];
        e.beta_b = betas[1][15:0];
        e.beta_c = betas[2][15:0];
      end else begin
        e.kind = cgd_pkg::KindDirection;
        e.out_index = w.element_index;
        for (int c = 0; c < 3; c++) begin
          d = ((longint'(prev_dir[c][idx]) * longint'(betas[c])) >>> 16) + g[c];
          if (d > 64'sd2147483647) d = 64'sd2147483647;
          if (d < -64'sd2147483648) d = -64'sd2147483648;
          prev_dir[c][idx] = int'(d);
        end
        e.dir_a = prev_dir[0][idx];
        e.dir_b = prev_dir[1][idx];
        e.dir_c = prev_dir[2][idx];
      end
      expected_words.push_back(e);
    endfunction

    function void check_result(cgd_pkg::out_word_t r);
      cgd_pkg::out_word_t e;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %p", r);
        return;
      end
      e = expected_words.pop_front();
      if (r.kind !== e.kind || r.out_index !== e.out_index || r.dir_a !== e.dir_a ||
          r.dir_b !== e.dir_b || r.dir_c !== e.dir_c || r.beta_a !== e.beta_a ||
          r.beta_b !== e.beta_b || r.beta_c !== e.beta_c) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch expected kind %0d idx %0d dir %h %h %h beta %h %h %h",
                   e.kind, e.out_index, e.dir_a, e.dir_b, e.dir_c,
                   e.beta_a, e.beta_b, e.beta_c);
          $display("         actual   kind %0d idx %0d dir %h %h %h beta %h %h %h",
                   r.kind, r.out_index, r.dir_a, r.dir_b, r.dir_c,
                   r.beta_a, r.beta_b, r.beta_c);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  cgd_pkg::in_word_t in_word = '0;
  logic busy;
  logic done;
  cgd_pkg::out_word_t result;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_data = 2'd0;

  direction_scoreboard sb = new();
  int cycles = 0;
  bit grad_known[cgd_pkg::GridElements];
  bit dir_known[cgd_pkg::GridElements];
  int grad_list[$];
  int dir_list[$];
  bit quiet_gaps = 1'b0;
  int sent = 0;

  conjugate_gradient_direction dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .in_word(in_word),
    .busy(busy),
    .done(done),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) sb.check_result(result);
    if (cycles > Limit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic cgd_pkg::in_word_t make_word(logic op, int idx, logic lst,
                                                  int a, int b, int c);
    cgd_pkg::in_word_t w;
    w.operation = op;
    w.element_index = idx[11:0];
    w.last = lst;
    w.grad_a = a;
    w.grad_b = b;
    w.grad_c = c;
    return w;
  endfunction

  function automatic int rand_grad();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
    if (r < 6) return $signed($urandom_range(0, 1 << 25)) - (1 << 24);
    if (r < 8) return $urandom;
    if (r == 8) return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    return $signed($urandom_range(0, 2)) - 1;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send(cgd_pkg::in_word_t w);
    start <= 1'b1;
    in_word <= w;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_input(w);
    sent++;
    if (w.operation == cgd_pkg::OpAccumulate && !grad_known[w.element_index]) begin
      grad_known[w.element_index] = 1'b1;
      grad_list.push_back(w.element_index);
    end
    if ((w.operation == cgd_pkg::OpApply || sb.mode == cgd_pkg::ModeInit) &&
        !dir_known[w.element_index]) begin
      dir_known[w.element_index] = 1'b1;
      dir_list.push_back(w.element_index);
    end
    @(negedge clk);
  endtask

  task automatic idle_gap();
    int r, n;
    r = $urandom_range(0, 19);
    n = (quiet_gaps || r < 12) ? 0 : (r < 18) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.expected_words.size() > 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_mode(logic [1:0] m);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= m;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.mode = m;
  endtask

  task automatic random_round();
    int len, idx;
    logic [1:0] m;
    m = sb.mode;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      if (m == cgd_pkg::ModeInit)
        idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, cgd_pkg::GridElements - 1)
                                          : $urandom_range(0, 63);
      else
        idx = grad_list[$urandom_range(0, grad_list.size() - 1)];
      send(make_word(cgd_pkg::OpAccumulate, idx,
                     (i == len - 1) && ($urandom_range(0, 19) != 0),
                     rand_grad(), rand_grad(), rand_grad()));
      idle_gap();
    end
    len = $urandom_range(1, 10);
    for (int i = 0; i < len; i++) begin
      idx = dir_list[$urandom_range(0, dir_list.size() - 1)];
      send(make_word(cgd_pkg::OpApply, idx, 1'($urandom_range(0, 1)),
                     rand_grad(), rand_grad(), rand_grad()));
      idle_gap();
    end
  endtask

  initial begin
    logic [1:0] modes[11] = '{2'd0, 2'd2, 2'd3, 2'd1, 2'd0, 2'd2, 2'd0, 2'd3, 2'd0,
                              2'd1, 2'd0};
    int target;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_mode(cgd_pkg::ModeInit);
    send(make_word(cgd_pkg::OpAccumulate, 0, 1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0));
    send(make_word(cgd_pkg::OpAccumulate, 4095, 1'b0, 32'sh8000_0000, -1, 1));
    send(make_word(cgd_pkg::OpAccumulate, 5, 1'b0, 0, 0, 0));
    send(make_word(cgd_pkg::OpAccumulate, 1, 1'b1, 32'sh10000, 32'sh8000, -32'sh10000));
    send(make_word(cgd_pkg::OpApply, 0, 1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000, 0));
    write_mode(cgd_pkg::ModeCompute);
    send(make_word(cgd_pkg::OpAccumulate, 1, 1'b0, 32'sh20000, 32'sh10000, -32'sh20000));
    send(make_word(cgd_pkg::OpAccumulate, 4095, 1'b1, 32'sh8000_0000, -1, 1));
    send(make_word(cgd_pkg::OpAccumulate, 5, 1'b1, 32'sh30000, -32'sh30000, 7));
    send(make_word(cgd_pkg::OpAccumulate, 0, 1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0));
    send(make_word(cgd_pkg::OpAccumulate, 1, 1'b1, 32'sh40000, 32'sh20000, -32'sh40000));
    send(make_word(cgd_pkg::OpApply, 0, 1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0));
    send(make_word(cgd_pkg::OpApply, 1, 1'b1, 32'sh8000_0000, 32'sh7FFF_FFFF, -1));
    send(make_word(cgd_pkg::OpApply, 4095, 1'b0, 0, 0, 0));
    write_mode(cgd_pkg::ModeZero);
    send(make_word(cgd_pkg::OpAccumulate, 1, 1'b1, 32'sh10000, 32'sh10000, 32'sh10000));
    send(make_word(cgd_pkg::OpApply, 1, 1'b0, 32'sh123, -32'sh456, 0));
    drain();

    for (int p = 0; p < 11; p++) begin
      write_mode(modes[p]);
      quiet_gaps = (p % 4 == 3);
      target = sent + 68;
      while (sent < target) random_round();
    end
    drain();

    sb.mismatches += sb.expected_words.size();
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// File: conjugate_gradient_direction.f
design/cgd_pkg.sv
design/cgd_datapath.sv
design/cgd_control.sv
design/conjugate_gradient_direction.sv
verif/tb.sv
